// ===== rtl/core/cfltsu_pkg.sv =====
// shared types and constants for the cfl time step / update coefficient block
// no dependencies
`default_nettype none

package cfltsu_pkg;

    localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
    localparam int          PADDR_W = 5;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_TIME_ACCURATE = 3'd0,
        REG_CFL           = 3'd1,
        REG_CURRENT_TIME  = 3'd2,
        REG_TIME_STEP     = 3'd3,
        REG_END_TIME      = 3'd4
    } reg_idx_t;

    localparam logic [31:0] CFL_RESET = 32'h0001_0000;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic        sat;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfltsu_div.sv =====
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor, saturating
// depends on cfltsu_pkg
`default_nettype none

module cfltsu_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfltsu_pkg::div_req_t req,
    output cfltsu_pkg::div_rsp_t      rsp
);
    import cfltsu_pkg::*;

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t     state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [32:0] trial;
    logic        fits;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        trial      = {rem_reg, quo_reg[31]};
        fits       = (trial >= {1'b0, req.den});
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    // zero divisor or quotient beyond 32 bits saturates
                    if (req.den == 32'd0 || req.num[63:32] >= req.den)
                    begin
                        quo_next  = SAT32;
                        sat_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next   = req.num[63:32];
                        quo_next   = req.num[31:0];
                        sat_next   = 1'b0;
                        cnt_next   = 5'd0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next = fits ? 32'(trial - {1'b0, req.den}) : trial[31:0];
                quo_next = {quo_reg[30:0], fits};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 5'd0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.sat  = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cfltsu_store.sv =====
// volume store: one write port, one registered read port
// no dependencies
`default_nettype none

module cfltsu_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic [31:0]        rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/cfl_time_step_update_coeff_top.sv =====
// top level: apb registers, cell sequencer, shared divider and volume store
// depends on cfltsu_pkg, cfltsu_div, cfltsu_store
//
//  channel   | dir | contents
//  s_axis    | in  | tdata[31:0] volume, [63:32] wave speed; tlast last_cell
//  m_axis    | out | tdata[5:0] cell_index, [37:6] coefficient, [38] written,
//            |     |   [39] saturated, [71:40] step_taken; tlast last_result
//  apb       | in  | registers mode flag, cfl, present time, requested step, stop time
//
// one shared divider does every division, one at a time
// a stored cell with positive volume first divides cfl times volume by wave speed,
// and the quotient lowers the step if smaller; a local cell then divides cfl by wave speed
// the last cell of a time-accurate run then walks every stored cell and divides the
// step by each positive volume; other stored cells give an unwritten zero result
// s_axis_tready is high only while idle; a held result stalls the sequencer
// reset clears control state and registers; the store itself is not cleared
`default_nettype none

module cfl_time_step_update_coeff_top #(
    parameter int MAX_CELLS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [63:0]                    s_axis_tdata,  // volume, wave speed
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [71:0]                         m_axis_tdata,  // index, coeff, wr, sat, step
    output logic                                m_axis_tlast,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cfltsu_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import cfltsu_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_CELLS);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_CELLS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MDIV, S_MWAIT, S_DECIDE, S_LWAIT,
        S_RD, S_RDW, S_GWAIT, S_OUT
    } state_t;

    // configuration registers
    logic        ta_reg;
    logic [31:0] cfl_reg, ct_reg, dt_reg, et_reg;
    logic        wr_cyc;
    reg_idx_t    widx;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] gi_reg, gi_next;
    logic             last_reg, last_next;
    logic             loop_reg, loop_next;
    logic [31:0]      step_reg, step_next;
    logic [31:0]      vol_reg, vol_next;
    logic [31:0]      ws_reg, ws_next;
    logic [63:0]      prod_reg, prod_next;
    div_req_t         dreq_reg, dreq_next;
    div_rsp_t         drsp;
    logic             ov_reg, ov_next;
    logic [CNT_W-1:0] o_idx_reg, o_idx_next;
    logic [31:0]      o_coeff_reg, o_coeff_next;
    logic             o_wr_reg, o_wr_next;
    logic             o_sat_reg, o_sat_next;
    logic [31:0]      o_step_reg, o_step_next;
    logic             o_last_reg, o_last_next;

    logic             accept;
    logic             stored;
    logic             vol_pos_in;
    logic [32:0]      t_sum;
    logic [31:0]      start_dt;
    logic [31:0]      rd_vol;
    logic             rd_pos;

    // apb
    assign pready = 1'b1;
    assign wr_cyc = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        unique case (widx)
            REG_TIME_ACCURATE: prdata = {31'd0, ta_reg};
            REG_CFL:           prdata = cfl_reg;
            REG_CURRENT_TIME:  prdata = ct_reg;
            REG_TIME_STEP:     prdata = dt_reg;
            REG_END_TIME:      prdata = et_reg;
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ta_reg  <= 1'b0;
            cfl_reg <= CFL_RESET;
            ct_reg  <= 32'd0;
            dt_reg  <= 32'd0;
            et_reg  <= 32'd0;
        end
        else if (wr_cyc)
        begin
            unique case (widx)
                REG_TIME_ACCURATE: ta_reg  <= pwdata[0];
                REG_CFL:           cfl_reg <= pwdata;
                REG_CURRENT_TIME:  ct_reg  <= pwdata;
                REG_TIME_STEP:     dt_reg  <= pwdata;
                REG_END_TIME:      et_reg  <= pwdata;
                default:           ;
            endcase
        end
    end

    // starting step clipped to the end time
    assign t_sum    = {1'b0, ct_reg} + {1'b0, dt_reg};
    assign start_dt = (t_sum > {1'b0, et_reg})
                      ? ((et_reg > ct_reg) ? (et_reg - ct_reg) : 32'd0)
                      : dt_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign stored        = (count_reg < MAX_CNT);
    assign vol_pos_in    = !s_axis_tdata[31] && (s_axis_tdata[31:0] != 32'd0);
    assign rd_pos        = !rd_vol[31] && (rd_vol != 32'd0);

    cfltsu_store #(.DEPTH(MAX_CELLS), .AW(IDX_W)) u_store (
        .clk     (clk),
        .wr_en   (accept && stored),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_axis_tdata[31:0]),
        .rd_addr (gi_reg[IDX_W-1:0]),
        .rd_data (rd_vol)
    );

    cfltsu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq_reg),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        gi_next      = gi_reg;
        last_next    = last_reg;
        loop_next    = loop_reg;
        step_next    = step_reg;
        vol_next     = vol_reg;
        ws_next      = ws_reg;
        prod_next    = prod_reg;
        dreq_next    = dreq_reg;
        dreq_next.start = 1'b0;
        ov_next      = ov_reg;
        o_idx_next   = o_idx_reg;
        o_coeff_next = o_coeff_reg;
        o_wr_next    = o_wr_reg;
        o_sat_next   = o_sat_reg;
        o_step_next  = o_step_reg;
        o_last_next  = o_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    vol_next  = s_axis_tdata[31:0];
                    ws_next   = s_axis_tdata[63:32];
                    last_next = s_axis_tlast;
                    loop_next = 1'b0;
                    idx_next  = stored ? count_reg : LAST_IDX;
                    if (count_reg == '0)
                    begin
                        step_next = start_dt;
                    end
                    if (stored)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = (stored && vol_pos_in) ? S_MUL : S_DECIDE;
                end
            end
            S_MUL:
            begin
                prod_next  = 64'(cfl_reg) * 64'(vol_reg);
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                dreq_next.start = 1'b1;
                dreq_next.num   = prod_reg;
                dreq_next.den   = ws_reg;
                state_next      = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (drsp.done)
                begin
                    if (drsp.quo < step_reg)
                    begin
                        step_next = drsp.quo;
                    end
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!ta_reg)
                begin
                    dreq_next.start = 1'b1;
                    dreq_next.num   = {16'd0, cfl_reg, 16'd0};
                    dreq_next.den   = ws_reg;
                    state_next      = S_LWAIT;
                end
                else if (last_reg)
                begin
                    gi_next    = '0;
                    loop_next  = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LWAIT:
            begin
                if (drsp.done)
                begin
                    o_idx_next   = idx_reg;
                    o_coeff_next = drsp.quo;
                    o_wr_next    = 1'b1;
                    o_sat_next   = drsp.sat;
                    o_step_next  = 32'd0;
                    o_last_next  = last_reg;
                    ov_next      = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_RD:
            begin
                // store read address is gi, data arrives next cycle
                state_next = S_RDW;
            end
            S_RDW:
            begin
                o_idx_next  = gi_reg;
                o_step_next = step_reg;
                o_last_next = (gi_reg + CNT_W'(1) == count_reg);
                if (rd_pos)
                begin
                    dreq_next.start = 1'b1;
                    dreq_next.num   = {16'd0, step_reg, 16'd0};
                    dreq_next.den   = rd_vol;
                    state_next      = S_GWAIT;
                end
                else
                begin
                    o_coeff_next = 32'd0;
                    o_wr_next    = 1'b0;
                    o_sat_next   = 1'b0;
                    ov_next      = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_GWAIT:
            begin
                if (drsp.done)
                begin
                    o_coeff_next = drsp.quo;
                    o_wr_next    = 1'b1;
                    o_sat_next   = drsp.sat;
                    ov_next      = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    ov_next = 1'b0;
                    if (loop_reg && (gi_reg + CNT_W'(1) != count_reg))
                    begin
                        gi_next    = gi_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            count_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        // a time-accurate cell other than the last gives no result and keeps the count
        if (state_reg == S_DECIDE && ta_reg && !last_reg)
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            step_reg   <= 32'd0;
            ov_reg     <= 1'b0;
            dreq_reg   <= '0;
            loop_reg   <= 1'b0;
            last_reg   <= 1'b0;
            gi_reg     <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            ov_reg     <= ov_next;
            dreq_reg   <= dreq_next;
            loop_reg   <= loop_next;
            last_reg   <= last_next;
            gi_reg     <= gi_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vol_reg     <= vol_next;
        ws_reg      <= ws_next;
        prod_reg    <= prod_next;
        o_idx_reg   <= o_idx_next;
        o_coeff_reg <= o_coeff_next;
        o_wr_reg    <= o_wr_next;
        o_sat_reg   <= o_sat_next;
        o_step_reg  <= o_step_next;
        o_last_reg  <= o_last_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {o_step_reg, o_sat_reg, o_wr_reg, o_coeff_reg, 6'(o_idx_reg)};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("cell count beyond capacity");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !o_wr_reg) |-> (o_coeff_reg == 32'd0 && !o_sat_reg))
        else $error("unwritten result carries data");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_MWAIT || state_reg == S_LWAIT
                       || state_reg == S_GWAIT))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire
